// File: rtl/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the fractional baud divisor search.
// ----------------------------------------------------------------------------
package fbd_pkg;

   localparam int unsigned PCLK_W      = 27;
   localparam int unsigned BAUD_W      = 23;
   localparam int unsigned DIV_W       = 16;
   localparam int unsigned MUL_W       = 4;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned MUL_LIMIT_D = 15;
   localparam logic [PCLK_W-1:0] PCLK_RESET = 27'd48000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAIN,
      ST_PLAIN_WAIT,
      ST_TRIAL,
      ST_DEN,
      ST_DLV,
      ST_DLV_WAIT,
      ST_BDEN,
      ST_BCK,
      ST_BCK_WAIT,
      ST_EVAL,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic [WORD_W-1:0]   dividend;
      logic [WORD_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [WORD_W-1:0]   quotient;
      logic [WORD_W-1:0]   remainder;
   } div_rsp_type;

endpackage

// File: rtl/fbd_divider.sv
// ----------------------------------------------------------------------------
// fbd_divider
// 32-bit unsigned restoring divider, one quotient bit per cycle.
// Division by zero yields all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
module fbd_divider
   import fbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int unsigned CNT_W = $clog2(WORD_W + 1);

   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = CNT_W'(WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: rtl/fractional_baud_divisor_search.sv
// Runs a plain divide first, then up to 120 trials of mul/add values when it is not exact.
// The shared one-bit-per-cycle 32-bit divider serves every divide (two divides per trial).
// An exact plain quotient answers without any trials.
// One item at a time; req_ready is low from acceptance until the result is taken.
// Synchronous active-high reset idles the sequencer and loads pclk_hz with 48000000.
// ----------------------------------------------------------------------------
// fractional_baud_divisor_search
// Searches divisor, mul and add values for a wanted baud rate.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_search
   import fbd_pkg::*;
#(
   parameter int unsigned MUL_LIMIT = MUL_LIMIT_D
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BAUD_W-1:0] req_baud_rate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIV_W-1:0]  rsp_divisor,
   output logic [MUL_W-1:0]  rsp_mul_val,
   output logic [MUL_W-1:0]  rsp_div_add_val,
   input  logic              csr_write,
   input  logic [PCLK_W-1:0] csr_pclk_hz
);

   state_type         state_ff, state_in;
   logic [PCLK_W-1:0] pclk_ff;
   logic [BAUD_W-1:0] baud_ff, baud_in;
   logic [MUL_W-1:0]  m_ff, m_in, a_ff, a_in;
   logic [WORD_W-1:0] num_ff, num_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [DIV_W-1:0]  dlv_ff, dlv_in;
   logic [WORD_W-1:0] err_min_ff, err_min_in;
   logic [DIV_W-1:0]  bdiv_ff, bdiv_in;
   logic [MUL_W-1:0]  bmul_ff, bmul_in, badd_ff, badd_in;
   logic              done_ff, done_in;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [WORD_W-1:0] mp, am, bq, err, dlv_w;
   logic [MUL_W:0]    am_n;

   fbd_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   always_comb begin
      mp   = WORD_W'(m_ff) * WORD_W'(pclk_ff);
      am_n = {1'b0, a_ff} + {1'b0, m_ff};
      am   = WORD_W'(am_n);
      bq   = (div_rsp.quotient + 32'd1) >> 1;
      err  = (bq >= WORD_W'(baud_ff)) ? bq - WORD_W'(baud_ff) : WORD_W'(baud_ff) - bq;
   end

   always_comb begin
      state_in    = state_ff;
      baud_in     = baud_ff;
      m_in        = m_ff;
      a_in        = a_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      dlv_in      = dlv_ff;
      err_min_in  = err_min_ff;
      bdiv_in     = bdiv_ff;
      bmul_in     = bmul_ff;
      badd_in     = badd_ff;
      done_in     = done_ff;
      div_req     = '0;
      dlv_w       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               baud_in  = req_baud_rate;
               bdiv_in  = '0;
               bmul_in  = MUL_W'(1);
               badd_in  = '0;
               state_in = (req_baud_rate == '0) ? ST_DONE : ST_PLAIN;
            end
         end
         ST_PLAIN: begin
            div_req.start    = 1'b1;
            div_req.dividend = WORD_W'(pclk_ff);
            div_req.divisor  = WORD_W'({baud_ff, 4'b0});
            state_in         = ST_PLAIN_WAIT;
         end
         ST_PLAIN_WAIT: begin
            if (div_rsp.done) begin
               bdiv_in = div_rsp.quotient[DIV_W-1:0];
               if (div_rsp.remainder == '0) begin
                  state_in = ST_DONE;
               end else begin
                  err_min_in  = WORD_W'(baud_ff);
                  m_in        = MUL_W'(1);
                  a_in        = '0;
                  done_in     = 1'b0;
                  state_in    = ST_TRIAL;
               end
            end
         end
         ST_TRIAL: begin
            num_in   = mp[WORD_W-2] ? (mp << 1) : (mp << 2);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = WORD_W'(baud_ff) * am;
            state_in = ST_DLV;
         end
         ST_DLV: begin
            div_req.start    = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor  = den_ff;
            state_in         = ST_DLV_WAIT;
         end
         ST_DLV_WAIT: begin
            if (div_rsp.done) begin
               if (mp[WORD_W-2]) dlv_w = ((div_rsp.quotient >> 4) + 32'd1) >> 1;
               else              dlv_w = ((div_rsp.quotient >> 5) + 32'd1) >> 1;
               dlv_in = dlv_w[DIV_W-1:0];
               if (dlv_w[DIV_W-1:0] == '0) dlv_in = DIV_W'(1);
               if (a_ff != '0 && dlv_w[DIV_W-1:0] < DIV_W'(2)) dlv_in = DIV_W'(2);
               state_in = ST_BDEN;
            end
         end
         ST_BDEN: begin
            den_in   = (WORD_W'(dlv_ff) * am) << 3;
            state_in = ST_BCK;
         end
         ST_BCK: begin
            div_req.start    = 1'b1;
            div_req.dividend = mp;
            div_req.divisor  = den_ff;
            state_in         = ST_BCK_WAIT;
         end
         ST_BCK_WAIT: begin
            if (div_rsp.done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (err < err_min_ff) begin
               err_min_in  = err;
               bdiv_in     = dlv_ff;
               bmul_in     = m_ff;
               badd_in     = a_ff;
               if (err == '0) done_in = 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (done_ff) begin
               state_in = ST_DONE;
            end else if (MUL_W'(a_ff + 1'b1) < m_ff) begin
               a_in     = MUL_W'(a_ff + 1'b1);
               state_in = ST_TRIAL;
            end else if (m_ff < MUL_W'(MUL_LIMIT)) begin
               m_in     = MUL_W'(m_ff + 1'b1);
               a_in     = '0;
               state_in = ST_TRIAL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pclk_ff  <= PCLK_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write) pclk_ff <= csr_pclk_hz;
      end
      baud_ff     <= baud_in;
      m_ff        <= m_in;
      a_ff        <= a_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      dlv_ff      <= dlv_in;
      err_min_ff  <= err_min_in;
      bdiv_ff     <= bdiv_in;
      bmul_ff     <= bmul_in;
      badd_ff     <= badd_in;
      done_ff     <= done_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_divisor     = bdiv_ff;
   assign rsp_mul_val     = bmul_ff;
   assign rsp_div_add_val = badd_ff;

endmodule

// File: rtl/fbd_checker.sv
// ----------------------------------------------------------------------------
// fbd_checker
// Port-level checks for the fractional baud divisor search.
// ----------------------------------------------------------------------------
module fbd_checker
   import fbd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [MUL_W-1:0] rsp_mul_val,
   input logic [MUL_W-1:0] rsp_div_add_val
);

   a_add_below_mul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_div_add_val < rsp_mul_val))
      else $error("add not below mul");

   a_mul_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mul_val != '0))
      else $error("mul zero");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_mul_val))
      else $error("result dropped");

endmodule

bind fractional_baud_divisor_search fbd_checker u_fbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_mul_val    (rsp_mul_val),
   .rsp_div_add_val(rsp_div_add_val)
);

// File: test/tb_fractional_baud_divisor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_baud_divisor_search
// Drives baud rate requests under several peripheral clock settings and
// checks every divisor/mul/add result against a built-in divisor search.
// ----------------------------------------------------------------------------
module tb_fractional_baud_divisor_search;
   import fbd_pkg::*;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic [MUL_W-1:0] mul_val;
      logic [MUL_W-1:0] add_val;
   } divisors_type;

   typedef struct {
      logic [BAUD_W-1:0] baud;
      bit                known;
      divisors_type      result;
   } vector_type;

   localparam int unsigned WATCHDOG_LIMIT = 200000;
   localparam int unsigned MAX_BAUD       = (1 << BAUD_W) - 1;
   localparam int unsigned MAX_PCLK       = (1 << PCLK_W) - 1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BAUD_W-1:0] req_baud_rate = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DIV_W-1:0]  rsp_divisor;
   logic [MUL_W-1:0]  rsp_mul_val;
   logic [MUL_W-1:0]  rsp_div_add_val;
   logic              csr_write = 1'b0;
   logic [PCLK_W-1:0] csr_pclk_hz = '0;

   logic [PCLK_W-1:0] pclk_setting = PCLK_RESET;
   divisors_type      divisors_due[$];
   bit                known_due[$];
   divisors_type      known_value[$];
   int unsigned       failures = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       burst_left = 0;
   int unsigned       stall_count = 0;
   bit                stall_mode = 1'b0;

   always #5 clock = ~clock;

   fractional_baud_divisor_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_baud_rate   (req_baud_rate),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_divisor     (rsp_divisor),
      .rsp_mul_val     (rsp_mul_val),
      .rsp_div_add_val (rsp_div_add_val),
      .csr_write       (csr_write),
      .csr_pclk_hz     (csr_pclk_hz)
   );

   function automatic divisors_type search_divisors(bit [31:0] pclk, bit [31:0] baud);
      divisors_type best;
      bit [31:0]    span;
      bit [31:0]    err_min;
      bit [31:0]    den;
      bit [31:0]    dlv;
      bit [31:0]    rate;
      bit [31:0]    err;
      bit [31:0]    m;
      bit [31:0]    a;
      bit           done;
      best = '{divisor: '0, mul_val: 4'd1, add_val: 4'd0};
      if (baud == 0) return best;
      span = 32'd16 * baud;
      best.divisor = 16'(pclk / span);
      if ((pclk % span) == 0) return best;
      err_min = baud;
      done = 1'b0;
      for (m = 1; m <= MUL_LIMIT_D && !done; m++) begin
         for (a = 0; a < m && !done; a++) begin
            den = baud * (a + m);
            if (((m * pclk * 32'd2) & 32'h8000_0000) != 0)
               dlv = ((((32'd2 * m * pclk) / den) / 32'd16) + 32'd1) / 32'd2;
            else
               dlv = ((((32'd4 * m * pclk) / den) / 32'd32) + 32'd1) / 32'd2;
            dlv &= 32'hFFFF;
            if (dlv == 0) dlv = 1;
            if (a > 0 && dlv < 2) dlv = 2;
            rate = (((pclk * m) / (dlv * (a + m) * 32'd8)) + 32'd1) / 32'd2;
            err = (rate >= baud) ? rate - baud : baud - rate;
            if (err < err_min) begin
               err_min = err;
               best = '{divisor: dlv[15:0], mul_val: m[3:0], add_val: a[3:0]};
               if (err == 0) done = 1'b1;
            end
         end
      end
      return best;
   endfunction

   // Expected values are captured at acceptance, under the clock setting in force.
   always @(posedge clock) begin
      if (!reset) begin
         divisors_type want;
         divisors_type got;
         if (req_valid && req_ready) begin
            want = search_divisors(32'(pclk_setting), 32'(req_baud_rate));
            divisors_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{divisor: rsp_divisor, mul_val: rsp_mul_val, add_val: rsp_div_add_val};
            if (divisors_due.size() == 0) begin
               $display("%0t: unexpected item div=%0d mul=%0d add=%0d", $time,
                        got.divisor, got.mul_val, got.add_val);
               failures++;
            end else begin
               want = divisors_due.pop_front();
               if (known_due.size() != 0 && known_due.pop_front()) begin
                  if (known_value.pop_front() != want) begin
                     $display("%0t: table entry disagrees with search", $time);
                     failures++;
                  end
               end
               if (got.divisor !== want.divisor) begin
                  $display("%0t: divisor expected %0d actual %0d", $time,
                           want.divisor, got.divisor);
                  failures++;
               end
               if (got.mul_val !== want.mul_val) begin
                  $display("%0t: mul_val expected %0d actual %0d", $time,
                           want.mul_val, got.mul_val);
                  failures++;
               end
               if (got.add_val !== want.add_val) begin
                  $display("%0t: div_add_val expected %0d actual %0d", $time,
                           want.add_val, got.add_val);
                  failures++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Receiver: alternates stretches of random stalls with stretches of none.
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode <= $urandom_range(0, 1);
         stall_count <= $urandom_range(20, 200);
      end else begin
         stall_count <= stall_count - 1;
      end
      rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   // Entered and left at a falling edge.
   task automatic send_baud(logic [BAUD_W-1:0] baud);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_baud_rate <= baud;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (divisors_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_pclk(logic [PCLK_W-1:0] value);
      csr_write <= 1'b1;
      csr_pclk_hz <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      pclk_setting = value;
      @(negedge clock);
   endtask

   function automatic logic [BAUD_W-1:0] random_baud();
      int unsigned b;
      case ($urandom_range(0, 3))
         0: b = $urandom_range(1, MAX_BAUD);
         1: b = $urandom_range(1, 2000);
         default: b = pclk_setting / (16 * $urandom_range(1, 400)) + $urandom_range(0, 3);
      endcase
      if (b == 0) b = 1;
      if (b > MAX_BAUD) b = MAX_BAUD;
      return b[BAUD_W-1:0];
   endfunction

   vector_type vectors[] = '{
      '{23'd0,       1'b1, '{16'd0,     4'd1, 4'd0}},
      '{23'd1,       1'b1, '{16'd50880, 4'd1, 4'd0}},
      '{23'd3000000, 1'b1, '{16'd1,     4'd1, 4'd0}},
      '{23'd250000,  1'b1, '{16'd12,    4'd1, 4'd0}},
      '{23'd8388607, 1'b0, '{16'd0,     4'd0, 4'd0}},
      '{23'd9600,    1'b0, '{16'd0,     4'd0, 4'd0}},
      '{23'd115200,  1'b0, '{16'd0,     4'd0, 4'd0}},
      '{23'd2999999, 1'b0, '{16'd0,     4'd0, 4'd0}},
      '{23'd4194304, 1'b0, '{16'd0,     4'd0, 4'd0}},
      '{23'd31250,   1'b0, '{16'd0,     4'd0, 4'd0}}
   };

   logic [PCLK_W-1:0] clock_settings[] = '{
      27'd1, MAX_PCLK[PCLK_W-1:0], 27'd0, 27'd14745600, 27'd0, 27'd0
   };

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (vectors[i]) begin
         known_due.push_back(vectors[i].known);
         known_value.push_back(vectors[i].result);
         send_baud(vectors[i].baud);
      end
      wait_drained();

      foreach (clock_settings[p]) begin
         if (p >= 4) clock_settings[p] = PCLK_W'($urandom_range(1, MAX_PCLK));
         write_pclk(clock_settings[p]);
         if (p == 2) begin
            send_baud(23'd1);
            send_baud(23'd9600);
            send_baud(MAX_BAUD[BAUD_W-1:0]);
         end else begin
            repeat (15) send_baud(random_baud());
         end
         wait_drained();
      end

      write_pclk(PCLK_RESET);
      repeat (12) send_baud(random_baud());
      wait_drained();
      repeat (100) @(negedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
rtl/fbd_pkg.sv
rtl/fbd_divider.sv
rtl/fractional_baud_divisor_search.sv
rtl/fbd_checker.sv
test/tb_fractional_baud_divisor_search.sv
